// File: hw/rtl/spq_pkg.sv
// shared constants, codes and types for the sorted array priority queue
// used by spq_datapath, spq_ctrl and sorted_array_priority_queue_top
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // memory read address select
  localparam logic [1:0] RD_HEAD  = 2'd0;
  localparam logic [1:0] RD_BELOW = 2'd1;
  localparam logic [1:0] RD_POS   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mem_rd;
    logic [1:0] rd_sel;
    logic       ins_wr_key;
    logic       ins_wr_data;
    logic       sh_wr;
    logic       pos_from_cnt;
    logic       pos_one;
    logic       pos_dec;
    logic       pos_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cap_head;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic key_less;
    logic sh_done;
  } dp_stat_t;

endpackage

// File: hw/rtl/spq_datapath.sv
// datapath: key store memory, position and count registers, head capture
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_datapath
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  logic signed [KEY_W-1:0] in_key,
  output dp_stat_t                stat,
  output logic signed [KEY_W-1:0] res_key,
  output logic [CNT_W-1:0]        cnt
);

  logic [KEY_W-1:0]        mem [CAPACITY];
  logic signed [KEY_W-1:0] rdata_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] res_key_r;
  logic [CNT_W-1:0]        pos_r;
  logic [CNT_W-1:0]        pos_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic [CNT_W-1:0]        pos_m1;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [KEY_W-1:0]        wr_data;
  logic                    wr_en;

  assign pos_m1 = pos_r - CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_BELOW: rd_addr = pos_m1[AW-1:0];
      RD_POS:   rd_addr = pos_r[AW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  assign wr_en   = cmd.ins_wr_key | cmd.ins_wr_data | cmd.sh_wr;
  assign wr_addr = cmd.sh_wr ? pos_m1[AW-1:0] : pos_r[AW-1:0];
  assign wr_data = cmd.ins_wr_key ? key_r : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.pos_from_cnt) begin
      pos_nxt = cnt_r;
    end else if (cmd.pos_one) begin
      pos_nxt = CNT_W'(1);
    end else if (cmd.pos_dec) begin
      pos_nxt = pos_m1;
    end else if (cmd.pos_inc) begin
      pos_nxt = pos_r + CNT_W'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.load) begin
      key_r     <= in_key;
      res_key_r <= '0;
    end else if (cmd.cap_head) begin
      res_key_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.full     = (cnt_r >= CNT_W'(CAPACITY));
  assign stat.empty    = (cnt_r == '0);
  assign stat.pos_zero = (pos_r == '0);
  assign stat.key_less = (key_r < rdata_r);
  assign stat.sh_done  = (pos_r >= cnt_r);

  assign res_key = res_key_r;
  assign cnt     = cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.full)
    else $error("insert into full store");

  a_no_rm_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !stat.empty)
    else $error("remove from empty store");

endmodule

// File: hw/rtl/spq_ctrl.sv
// controller state machine: sequences insert, remove and peek over the store
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_ctrl
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CMD_W-1:0]  in_cmd,
  output logic              in_stall,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd,
  input  logic              out_free,
  output logic              out_load,
  output logic [STAT_W-1:0] res_status
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_HEAD_RD  = 3'd3;
  localparam logic [2:0] S_HEAD_CAP = 3'd4;
  localparam logic [2:0] S_SH_RD    = 3'd5;
  localparam logic [2:0] S_SH_WR    = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          status_nxt = ST_OK;
          case (in_cmd) inside
            CMD_INSERT: begin
              if (stat.full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                cmd.pos_from_cnt = 1'b1;
                state_nxt        = S_INS_RD;
              end
            end
            CMD_REMOVE, CMD_PEEK: begin
              if (stat.empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_HEAD_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD: begin
        if (stat.pos_zero) begin
          cmd.ins_wr_key = 1'b1;
          cmd.cnt_inc    = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_BELOW;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.key_less) begin
          cmd.ins_wr_data = 1'b1;
          cmd.pos_dec     = 1'b1;
          state_nxt       = S_INS_RD;
        end else begin
          cmd.ins_wr_key = 1'b1;
          cmd.cnt_inc    = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_HEAD_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_HEAD;
        state_nxt  = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        cmd.cap_head = 1'b1;
        if (cmd_r == CMD_REMOVE) begin
          cmd.pos_one = 1'b1;
          state_nxt   = S_SH_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_RD: begin
        if (stat.sh_done) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RD_POS;
          state_nxt  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr   = 1'b1;
        cmd.pos_inc = 1'b1;
        state_nxt   = S_SH_RD;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
    end
  end

  assign res_status = status_r;

  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.ins_wr_key, cmd.ins_wr_data, cmd.sh_wr}) <= 1)
    else $error("two memory writes in one cycle");

  a_shift_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_WR) |-> (cmd_r == CMD_REMOVE))
    else $error("shift outside remove");

endmodule

// File: hw/rtl/sorted_array_priority_queue_top.sv
// top level of the sorted array priority queue: controller, datapath, output register
// depends on spq_pkg, spq_ctrl and spq_datapath
`timescale 1ns / 1ps

// bounded min-priority queue of up to 64 signed 32-bit keys, kept ascending
// input word: in_cmd (insert, remove smallest, peek smallest) and in_key
// result word: out_result_key, out_status (ok, empty, full) and out_occupancy
// both channels use valid/stall; a word moves when valid is high, stall low
// one result word per input word, in input order
// one word is worked on at a time; in_stall stays high until its result
// is loaded into the output register
// how a word is worked on:
//   insert: keys above the new key move up one slot, then the new key is written
//   peek reads the head; remove reads the head, then shifts every other key down one slot
//   full insert, empty remove/peek or unused cmd: no key memory access
// at most one key memory read or write per cycle; a key move reads, then writes
// the output register frees while a result waits only if out_stall is low
// out_stall holds the result word and, after the next word, holds in_stall
// reset (rst_n low, synchronous) empties the queue and drops out_valid
// the key memory needs no clearing after reset

module sorted_array_priority_queue_top
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [KEY_W-1:0] out_result_key,
  output logic [STAT_W-1:0]       out_status,
  output logic [OCC_W-1:0]        out_occupancy
);

  dp_cmd_t                 dcmd;
  dp_stat_t                dstat;
  logic signed [KEY_W-1:0] res_key;
  logic [CNT_W-1:0]        cnt;
  logic [STAT_W-1:0]       res_status;
  logic                    out_free;
  logic                    out_load;
  logic                    out_valid_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [OCC_W-1:0]        out_occ_r;

  assign out_free = !out_valid_r || !out_stall;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_stall   (in_stall),
    .stat       (dstat),
    .cmd        (dcmd),
    .out_free   (out_free),
    .out_load   (out_load),
    .res_status (res_status)
  );

  spq_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (dcmd),
    .in_key  (in_key),
    .stat    (dstat),
    .res_key (res_key),
    .cnt     (cnt)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r    <= res_key;
      out_status_r <= res_status;
      out_occ_r    <= OCC_W'(cnt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_key = out_key_r;
  assign out_status     = out_status_r;
  assign out_occupancy  = out_occ_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_key_r == '0))
    else $error("error word with nonzero key");

endmodule
